@@ hw/rtl/masked_roi_mean_accumulator_defines.svh @@
// assertion macros shared by the checker of the masked roi mean accumulator
// depends on nothing; expects i_clk and i_rst_n in the using scope
`ifndef MASKED_ROI_MEAN_ACCUMULATOR_DEFINES_SVH
`define MASKED_ROI_MEAN_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, held off during reset
`define MRA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, held off during reset
`define MRA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mra_pkg.sv @@
// types and constants of the masked roi mean accumulator
// no dependencies
package mra_pkg;

    localparam int unsigned MaxVoxels = 16777216;
    localparam int unsigned CountW    = 25;
    localparam int unsigned TermW     = 50;
    localparam int unsigned QueueDepth = 4;

    // register indexes
    localparam logic [2:0] RegMaskThreshold = 3'd0;
    localparam logic [2:0] RegRangeLow      = 3'd1;
    localparam logic [2:0] RegRangeHigh     = 3'd2;
    localparam logic [2:0] RegRangeEnable   = 3'd3;
    localparam logic [2:0] RegDefinedOnly   = 3'd4;
    localparam logic [2:0] RegWeightMode    = 3'd5;
    localparam logic [2:0] RegMaskAbsolute  = 3'd6;
    localparam logic [2:0] RegMeanScale     = 3'd7;

    // classified item passed from front to back
    typedef struct packed {
        logic signed [TermW-1:0] term;
        logic                    counted;
        logic                    last;
        logic                    prev_ok;
    } t_item;

    // filter settings seen by the front
    typedef struct packed {
        logic signed [31:0] mask_threshold;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic               range_enable;
        logic               defined_only;
        logic               weight_mode;
        logic               mask_absolute;
    } t_filter;

    // one frame result
    typedef struct packed {
        logic        [15:0]       frame_number;
        logic signed [63:0]       frame_sum;
        logic        [CountW-1:0] voxel_count;
        logic signed [31:0]       frame_mean;
        logic signed [31:0]       mean_difference;
        logic                     frame_empty;
        logic                     saturated;
    } t_result;

endpackage

@@ hw/rtl/mra_front.sv @@
// front: takes voxel transactions, applies the filter tests, forms the weighted term
// depends on mra_pkg
module mra_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mra_pkg::t_filter    i_flt,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_voxel_value,
    input  logic                i_voxel_ok,
    input  logic signed [31:0]  i_mask_value,
    input  logic                i_frame_end,
    input  logic                i_prev_frame_counted,
    output logic                o_push,
    output mra_pkg::t_item      o_item,
    input  logic                i_full
);
    import mra_pkg::*;

    logic               r_valid;
    logic signed [64:0] r_prod;
    logic               r_counted, r_last, r_prev_ok;

    logic signed [32:0] msk;
    logic               pass, counted, acc;
    logic signed [64:0] n_prod, rounded;

    // filter tests
    always_comb begin
        msk = {i_mask_value[31], i_mask_value};
        if (i_flt.mask_absolute && i_mask_value[31]) begin
            msk = -msk;
        end
        pass = 1'b1;
        if (i_flt.range_enable) begin
            pass = (i_voxel_value > i_flt.range_low) && (i_voxel_value < i_flt.range_high);
        end
        if (i_flt.defined_only) begin
            pass = pass && i_voxel_ok && (i_voxel_value != 32'sd0);
        end
        counted = pass && (i_flt.weight_mode ||
                           (msk > $signed({i_flt.mask_threshold[31], i_flt.mask_threshold})));
        // plain voxels ride as voxel << 16 so the same truncation returns them
        if (i_flt.weight_mode) begin
            n_prod = 65'(i_voxel_value * msk);
        end else begin
            n_prod = {{17{i_voxel_value[31]}}, i_voxel_value, 16'd0};
        end
    end

    assign o_ready = !r_valid || !i_full;
    assign acc     = i_valid && o_ready;
    assign o_push  = r_valid && !i_full;

    // stage register after the multiplier
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (acc) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
        if (acc) begin
            r_prod    <= n_prod;
            r_counted <= counted;
            r_last    <= i_frame_end;
            r_prev_ok <= i_prev_frame_counted;
        end
    end

    // shift by 16 rounding toward zero
    always_comb begin
        rounded = r_prod[64] ? ((r_prod + 65'sd65535) >>> 16) : (r_prod >>> 16);
        o_item.term    = rounded[TermW-1:0];
        o_item.counted = r_counted;
        o_item.last    = r_last;
        o_item.prev_ok = r_prev_ok;
    end

endmodule

@@ hw/rtl/mra_queue.sv @@
// short fifo of classified items between front and back
// depends on mra_pkg
module mra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mra_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mra_pkg::t_item o_item
);
    import mra_pkg::*;

    localparam int unsigned AW = $clog2(QueueDepth);

    t_item         r_mem [QueueDepth];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ hw/rtl/mra_back.sv @@
// back: saturating accumulation, frame-end divide, scale and difference
// depends on mra_pkg
module mra_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic signed [31:0] i_mean_scale,
    input  logic               i_valid,
    output logic               o_pop,
    input  mra_pkg::t_item     i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output mra_pkg::t_result   o_result
);
    import mra_pkg::*;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_DIV  = 6'b000100,
        ST_MUL0 = 6'b001000,
        ST_MUL1 = 6'b010000,
        ST_FIN  = 6'b100000
    } t_state;

    t_state             r_state;
    logic signed [63:0] r_sum;
    logic [CountW-1:0]  r_cnt;
    logic               r_ovf, r_prev_ok, r_neg;
    logic signed [31:0] r_prev_mean;
    logic [15:0]        r_frame;
    logic [63:0]        r_dvd;
    logic [CountW-1:0]  r_rem;
    logic [5:0]         r_i;
    logic [63:0]        r_lo, r_hi;
    logic               r_oval;
    t_result            r_res;

    logic signed [64:0] sum_ext;
    logic signed [63:0] n_sum;
    logic               sum_hit;
    logic [CountW:0]    rem_sh;
    logic               ge;
    logic [31:0]        scale_mag;
    logic [63:0]        prod_r;
    logic signed [31:0] mean;
    logic               mean_hit;
    logic signed [32:0] diff_w;
    logic signed [31:0] diff;
    logic               out_free;

    assign o_pop    = i_valid && (r_state == ST_IDLE);
    assign out_free = !r_oval || i_ready;
    assign o_valid  = r_oval;
    assign o_result = r_res;

    // saturating add of the term
    always_comb begin
        sum_ext = {r_sum[63], r_sum} + 65'(i_item.term);
        sum_hit = (sum_ext[64] != sum_ext[63]);
        if (sum_hit) begin
            n_sum = sum_ext[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
        end else begin
            n_sum = sum_ext[63:0];
        end
    end

    // one restoring divide step
    always_comb begin
        rem_sh = {r_rem, r_dvd[63]};
        ge     = (rem_sh >= {1'b0, r_cnt});
    end

    assign scale_mag = i_mean_scale[31] ? 32'(-i_mean_scale) : i_mean_scale;

    // scaled mean and difference from the registered partial products
    always_comb begin
        prod_r   = (r_hi << 16) + (r_lo >> 16);
        mean_hit = 1'b0;
        mean     = '0;
        if (r_cnt != '0) begin
            if (r_hi >= (64'd1 << 47)) begin
                mean_hit = 1'b1;
                mean     = r_neg ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
            end else if (!r_neg) begin
                if (prod_r > 64'h7FFF_FFFF) begin
                    mean_hit = 1'b1;
                    mean     = {1'b0, {31{1'b1}}};
                end else begin
                    mean = prod_r[31:0];
                end
            end else begin
                if (prod_r > 64'h8000_0000) begin
                    mean_hit = 1'b1;
                    mean     = {1'b1, 31'd0};
                end else begin
                    mean = 32'(-prod_r[31:0]);
                end
            end
        end
        diff_w = {mean[31], mean} - {r_prev_mean[31], r_prev_mean};
        if (!r_prev_ok) begin
            diff = '0;
        end else if (diff_w[32] != diff_w[31]) begin
            diff = diff_w[32] ? {1'b1, 31'd0} : {1'b0, {31{1'b1}}};
        end else begin
            diff = diff_w[31:0];
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_prev_mean <= '0;
            r_frame     <= '0;
            r_oval      <= 1'b0;
        end else begin
            // the final state loads the next result itself
            if (r_oval && i_ready && (r_state != ST_FIN)) begin
                r_oval <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        if (i_item.counted) begin
                            r_sum <= n_sum;
                            r_ovf <= r_ovf | sum_hit;
                            if (r_cnt < CountW'(MaxVoxels)) begin
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end
                        if (i_item.last) begin
                            r_prev_ok <= i_item.prev_ok;
                            r_state   <= ST_PREP;
                        end
                    end
                end
                ST_PREP: begin
                    r_dvd   <= r_sum[63] ? 64'(-r_sum) : r_sum;
                    r_rem   <= '0;
                    r_i     <= '0;
                    r_neg   <= r_sum[63] ^ i_mean_scale[31];
                    r_state <= (r_cnt == '0) ? ST_FIN : ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= ge ? CountW'(rem_sh - {1'b0, r_cnt}) : rem_sh[CountW-1:0];
                    r_dvd <= {r_dvd[62:0], ge};
                    r_i   <= r_i + 1'b1;
                    if (r_i == 6'd63) begin
                        r_state <= ST_MUL0;
                    end
                end
                ST_MUL0: begin
                    r_lo    <= r_dvd[31:0] * scale_mag;
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_hi    <= r_dvd[63:32] * scale_mag;
                    r_state <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        r_oval                <= 1'b1;
                        r_res.frame_number    <= r_frame + 1'b1;
                        r_res.frame_sum       <= r_sum;
                        r_res.voxel_count     <= r_cnt;
                        r_res.frame_mean      <= mean;
                        r_res.mean_difference <= diff;
                        r_res.frame_empty     <= (r_cnt == '0);
                        r_res.saturated       <= r_ovf | mean_hit;
                        r_frame               <= r_frame + 1'b1;
                        r_prev_mean           <= mean;
                        r_sum                 <= '0;
                        r_cnt                 <= '0;
                        r_ovf                 <= 1'b0;
                        r_state               <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ hw/rtl/masked_roi_mean_accumulator.sv @@
// Masked ROI mean accumulator. Voxel transactions are taken one per cycle while
// the front fifo has room; voxels that are not the last of a frame are taken by the
// back end one per cycle while it is idle. The last voxel of a frame starts a
// bit-serial divide of |sum| by count and two 32x32 partial products for the scale
// (an empty frame skips both), and the back end takes no voxels until it is done;
// the 4-deep fifo between front and back absorbs voxels during that time.
// Depends on mra_pkg, mra_front, mra_queue and mra_back.
module masked_roi_mean_accumulator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // voxel stream
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [63:0]   i_s_axis_tdata,  // voxel_value[31:0], mask_value[63:32]
    input  logic [1:0]    i_s_axis_tuser,  // voxel_ok[0], prev_frame_counted[1]
    input  logic          i_s_axis_tlast,  // frame_end
    // frame results
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    // frame_number[15:0], frame_sum[79:16], voxel_count[104:80],
    // frame_mean[136:105], mean_difference[168:137], zero pad [175:169]
    output logic [175:0]  o_m_axis_tdata,
    output logic [1:0]    o_m_axis_tuser,  // frame_empty[0], saturated[1]
    // register port
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [4:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);
    import mra_pkg::*;

    t_filter            r_flt;
    logic signed [31:0] r_mean_scale;
    logic               wr;
    logic [2:0]         idx;

    logic    push, full, q_valid, pop;
    t_item   f_item, q_item;
    t_result res;

    assign o_pready = 1'b1;
    assign idx      = i_paddr[4:2];
    assign wr       = i_psel && i_penable && i_pwrite;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flt        <= '0;
            r_mean_scale <= 32'sd65536;
        end else if (wr) begin
            unique case (idx)
                RegMaskThreshold: r_flt.mask_threshold <= i_pwdata;
                RegRangeLow:      r_flt.range_low      <= i_pwdata;
                RegRangeHigh:     r_flt.range_high     <= i_pwdata;
                RegRangeEnable:   r_flt.range_enable   <= i_pwdata[0];
                RegDefinedOnly:   r_flt.defined_only   <= i_pwdata[0];
                RegWeightMode:    r_flt.weight_mode    <= i_pwdata[0];
                RegMaskAbsolute:  r_flt.mask_absolute  <= i_pwdata[0];
                RegMeanScale:     r_mean_scale         <= i_pwdata;
                default: ;
            endcase
        end
    end

    // register reads
    always_comb begin
        unique case (idx)
            RegMaskThreshold: o_prdata = r_flt.mask_threshold;
            RegRangeLow:      o_prdata = r_flt.range_low;
            RegRangeHigh:     o_prdata = r_flt.range_high;
            RegRangeEnable:   o_prdata = {31'd0, r_flt.range_enable};
            RegDefinedOnly:   o_prdata = {31'd0, r_flt.defined_only};
            RegWeightMode:    o_prdata = {31'd0, r_flt.weight_mode};
            RegMaskAbsolute:  o_prdata = {31'd0, r_flt.mask_absolute};
            RegMeanScale:     o_prdata = r_mean_scale;
            default:          o_prdata = '0;
        endcase
    end

    mra_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_flt                (r_flt),
        .i_valid              (i_s_axis_tvalid),
        .o_ready              (o_s_axis_tready),
        .i_voxel_value        (i_s_axis_tdata[31:0]),
        .i_voxel_ok           (i_s_axis_tuser[0]),
        .i_mask_value         (i_s_axis_tdata[63:32]),
        .i_frame_end          (i_s_axis_tlast),
        .i_prev_frame_counted (i_s_axis_tuser[1]),
        .o_push               (push),
        .o_item               (f_item),
        .i_full               (full)
    );

    mra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    mra_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mean_scale (r_mean_scale),
        .i_valid      (q_valid),
        .o_pop        (pop),
        .i_item       (q_item),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_result     (res)
    );

    // result packing
    assign o_m_axis_tdata = {7'd0, res.mean_difference, res.frame_mean, res.voxel_count,
                             res.frame_sum, res.frame_number};
    assign o_m_axis_tuser = {res.saturated, res.frame_empty};

endmodule

@@ hw/rtl/mra_checker.sv @@
// port-level checks for the masked roi mean accumulator, bound to the top level
// depends on masked_roi_mean_accumulator_defines.svh
`include "masked_roi_mean_accumulator_defines.svh"

module mra_port_checks (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         o_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [175:0] o_m_axis_tdata,
    input logic [1:0]   o_m_axis_tuser
);

    logic [177:0] res_bits;

    assign res_bits = {o_m_axis_tuser, o_m_axis_tdata};

    // stalled result holds
    `MRA_ASSERT_NEXT(a_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(res_bits), "stalled result changed")

    // empty frame reports zero count and zero mean
    `MRA_ASSERT_NOW(a_empty, o_m_axis_tvalid && o_m_axis_tuser[0], o_m_axis_tdata[104:80] == 25'd0 && o_m_axis_tdata[136:105] == 32'd0, "empty frame with data")

    // zero count is always flagged empty
    `MRA_ASSERT_NOW(a_flag, o_m_axis_tvalid && o_m_axis_tdata[104:80] == 25'd0, o_m_axis_tuser[0], "zero count not flagged")

    // count never exceeds its limit
    `MRA_ASSERT_NOW(a_cap, o_m_axis_tvalid, o_m_axis_tdata[104:80] <= 25'd16777216, "count above limit")

endmodule

bind masked_roi_mean_accumulator mra_port_checks u_mra_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

@@ tb/mra_checker.sv @@
// frame result checker for the masked roi mean accumulator testbench
// watches the register port and both streams; depends on mra_pkg
module mra_checker (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    input  logic           i_s_axis_tready,
    input  logic [63:0]    i_s_axis_tdata,  // voxel_value[31:0], mask_value[63:32]
    input  logic [1:0]     i_s_axis_tuser,  // voxel_ok[0], prev_frame_counted[1]
    input  logic           i_s_axis_tlast,  // frame_end
    input  logic           i_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    input  logic [175:0]   i_m_axis_tdata,  // number, sum, count, mean, difference, pad
    input  logic [1:0]     i_m_axis_tuser,  // frame_empty[0], saturated[1]
    input  logic           i_psel,
    input  logic           i_penable,
    input  logic           i_pwrite,
    input  logic [4:0]     i_paddr,
    input  logic [31:0]    i_pwdata,
    input  logic           i_pready,
    output int             o_fail_count,
    output int             o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mra_pkg::*;

    // shadow of the register file
    logic signed [31:0] thr, rng_lo, rng_hi, scale;
    logic               rng_en, def_only, wmode, mabs;

    // shadow of the accumulator state
    logic signed [63:0] acc_sum;
    logic [24:0]        acc_count;
    logic signed [31:0] last_mean;
    logic [15:0]        frame_no;
    logic               acc_ovf;

    t_result frames_due[$];
    int      fails;

    assign o_fail_count = fails;
    assign o_pending    = frames_due.size();

    // scale * sum / count: |sum| / count times |scale| >> 16, rounded toward zero, signed and clamped to 32 bits
    function automatic logic signed [31:0] mean_of(input logic signed [63:0] s,
                                                    input logic [24:0] n,
                                                    output logic clipped);
        logic [63:0]  q;
        logic [63:0]  sc;
        logic [127:0] prod;
        logic [127:0] r;
        logic         neg;
        q = (s < 0 ? 64'd0 - 64'(s) : 64'(s)) / {39'd0, n};
        sc = scale < 0 ? 64'd0 - 64'(longint'(scale)) : 64'(longint'(scale));
        prod = {64'd0, q} * {64'd0, sc};
        r = prod >> 16;
        neg = (s < 0) != (scale < 0);
        clipped = 1'b0;
        if (!neg) begin
            if (r > 128'h7fff_ffff) begin
                clipped = 1'b1;
                return 32'h7fff_ffff;
            end
            return 32'(r);
        end
        if (r > 128'h8000_0000) begin
            clipped = 1'b1;
            return 32'h8000_0000;
        end
        return 32'(128'd0 - r);
    endfunction

    // classify one voxel, accumulate, and queue a frame result at frame end
    task automatic absorb_voxel(input logic signed [31:0] vox, input logic ok,
                                input logic signed [31:0] mask_in, input logic last,
                                input logic prev_ok);
        longint             m;
        longint             term;
        longint             p;
        longint unsigned    pm;
        logic signed [64:0] wide;
        logic               pass;
        logic               clipped;
        longint             diff;
        t_result            r;
        m = longint'(mask_in);
        if (mabs && m < 0) m = -m;
        pass = 1'b1;
        if (rng_en) pass = (vox > rng_lo) && (vox < rng_hi);
        if (def_only) pass = pass && ok && (vox != 0);
        if (pass && (wmode || m > longint'(thr))) begin
            term = longint'(vox);
            if (wmode) begin
                p = longint'(vox) * m;
                pm = (p < 0 ? 64'd0 - 64'(p) : 64'(p)) >> 16;
                term = p < 0 ? -longint'(pm) : longint'(pm);
            end
            wide = {acc_sum[63], acc_sum} + {term[63], 64'(term)};
            if (wide > 65'sh0_7fff_ffff_ffff_ffff) begin
                acc_sum = 64'h7fff_ffff_ffff_ffff;
                acc_ovf = 1'b1;
            end else if (wide < -65'sh0_8000_0000_0000_0000) begin
                acc_sum = 64'h8000_0000_0000_0000;
                acc_ovf = 1'b1;
            end else begin
                acc_sum = wide[63:0];
            end
            if (acc_count < MaxVoxels) acc_count = acc_count + 1'b1;
        end
        if (!last) return;
        frame_no = frame_no + 1'b1;
        clipped = 1'b0;
        r.frame_number = frame_no;
        r.frame_sum    = acc_sum;
        r.voxel_count  = acc_count;
        r.frame_empty  = acc_count == 0;
        r.frame_mean   = acc_count == 0 ? 32'sd0 : mean_of(acc_sum, acc_count, clipped);
        r.saturated    = acc_ovf || clipped;
        diff = longint'(r.frame_mean) - longint'(last_mean);
        if (!prev_ok) diff = 0;
        else if (diff > 64'sh7fff_ffff) diff = 64'sh7fff_ffff;
        else if (diff < -64'sh8000_0000) diff = -64'sh8000_0000;
        r.mean_difference = 32'(diff);
        frames_due.push_back(r);
        last_mean = r.frame_mean;
        acc_sum   = 0;
        acc_count = 0;
        acc_ovf   = 1'b0;
    endtask

    // compare one result transaction with the oldest expected frame
    task automatic check_frame();
        t_result want;
        t_result got;
        got.frame_number    = i_m_axis_tdata[15:0];
        got.frame_sum       = i_m_axis_tdata[79:16];
        got.voxel_count     = i_m_axis_tdata[104:80];
        got.frame_mean      = i_m_axis_tdata[136:105];
        got.mean_difference = i_m_axis_tdata[168:137];
        got.frame_empty     = i_m_axis_tuser[0];
        got.saturated       = i_m_axis_tuser[1];
        if (frames_due.size() == 0) begin
            fails++;
            if (fails <= 10) $display("unexpected frame result %p", got);
            return;
        end
        want = frames_due.pop_front();
        if (got != want || i_m_axis_tdata[175:169] != 0) begin
            fails++;
            if (fails <= 10) $display("frame mismatch\n  expected %p\n  actual   %p", want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr = 0; rng_lo = 0; rng_hi = 0; scale = 32'sd65536;
            rng_en = 0; def_only = 0; wmode = 0; mabs = 0;
            acc_sum = 0; acc_count = 0; last_mean = 0; frame_no = 0; acc_ovf = 0;
            frames_due.delete();
            fails = 0;
        end else begin
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    RegMaskThreshold: thr      = i_pwdata;
                    RegRangeLow:      rng_lo   = i_pwdata;
                    RegRangeHigh:     rng_hi   = i_pwdata;
                    RegRangeEnable:   rng_en   = i_pwdata[0];
                    RegDefinedOnly:   def_only = i_pwdata[0];
                    RegWeightMode:    wmode    = i_pwdata[0];
                    RegMaskAbsolute:  mabs     = i_pwdata[0];
                    RegMeanScale:     scale    = i_pwdata;
                    default: ;
                endcase
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                absorb_voxel(i_s_axis_tdata[31:0], i_s_axis_tuser[0], i_s_axis_tdata[63:32],
                             i_s_axis_tlast, i_s_axis_tuser[1]);
            if (i_m_axis_tvalid && i_m_axis_tready) check_frame();
        end
    end
endmodule

@@ tb/tb_masked_roi_mean_accumulator.sv @@
// testbench top for the masked roi mean accumulator: clock, reset, register
// writes, voxel stimulus and verdict; depends on mra_pkg and mra_checker
module tb_masked_roi_mean_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import mra_pkg::*;

    localparam int CycleLimit = 600000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic [63:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         s_tlast = 1'b0;
    logic         s_tready;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [175:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;
    int           fail_count;
    int           pending;

    // idling modes: 0 none, 1 sender idle, 2 receiver stall, 3 both light
    int           idle_mode = 0;
    logic         long_hold_req = 1'b0;
    logic         long_hold_done = 1'b0;
    int           hold_left = 0;
    int           cycles = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    masked_roi_mean_accumulator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser), .i_s_axis_tlast(s_tlast),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .o_prdata(prdata), .o_pready(pready)
    );

    mra_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_tvalid), .i_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser), .i_s_axis_tlast(s_tlast),
        .i_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .i_m_axis_tdata(m_tdata), .i_m_axis_tuser(m_tuser),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite), .i_paddr(paddr),
        .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // result side: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (long_hold_req && !long_hold_done) begin
            m_tready <= 1'b0;
            hold_left <= 400;
            long_hold_done <= 1'b1;
        end else begin
            case (idle_mode)
                2:       m_tready <= $urandom_range(0, 99) >= 54;
                3:       m_tready <= $urandom_range(0, 99) >= 17;
                default: m_tready <= 1'b1;
            endcase
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // register write: setup phase, access phase held until pready, then an idle phase
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk iff pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // one voxel transaction, with optional idle cycles in front
    task automatic send_voxel(input logic [31:0] vox, input logic ok, input logic [31:0] msk,
                              input logic last, input logic prev_ok);
        int gap_pct;
        gap_pct = idle_mode == 1 ? 54 : (idle_mode == 3 ? 17 : 0);
        while ($urandom_range(0, 99) < gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {msk, vox};
        s_tuser <= {prev_ok, ok};
        s_tlast <= last;
        @(posedge i_clk iff s_tready);
    endtask

    // settle the block before touching registers
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    // value biased toward the extremes and small magnitudes
    function automatic logic [31:0] pick32();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'($urandom_range(0, 1 << 21)) - 32'h0010_0000;
            4:       return 32'h0001_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic program_all(input logic [31:0] t, input logic [31:0] lo,
                               input logic [31:0] hi, input logic [3:0] flags,
                               input logic [31:0] sc);
        reg_write(RegMaskThreshold, t);
        reg_write(RegRangeLow, lo);
        reg_write(RegRangeHigh, hi);
        reg_write(RegRangeEnable, {31'd0, flags[0]});
        reg_write(RegDefinedOnly, {31'd0, flags[1]});
        reg_write(RegWeightMode, {31'd0, flags[2]});
        reg_write(RegMaskAbsolute, {31'd0, flags[3]});
        reg_write(RegMeanScale, sc);
    endtask

    initial begin
        int len;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset settings, extremes, empty frame, tiny frames
        send_voxel(32'h7fff_ffff, 1, 32'h7fff_ffff, 0, 0);
        send_voxel(32'h8000_0000, 0, 32'h0000_0001, 0, 0);
        send_voxel(32'h0000_0000, 1, 32'h8000_0000, 1, 0);
        send_voxel(32'h0001_0000, 1, 32'h0000_0000, 1, 1);
        send_voxel(32'h7fff_ffff, 1, 32'h0001_0000, 1, 1);
        send_voxel(32'h8000_0000, 1, 32'h0001_0000, 1, 1);
        drain();
        // weight mode with absolute mask, full-scale products
        program_all(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 4'b1111, 32'h7fff_ffff);
        send_voxel(32'h8000_0000, 1, 32'h8000_0000, 0, 0);
        send_voxel(32'h7fff_ffff, 1, 32'h8000_0000, 0, 0);
        send_voxel(32'h0000_0000, 1, 32'h7fff_ffff, 0, 0);
        send_voxel(32'hffff_0000, 0, 32'hffff_0000, 1, 1);
        send_voxel(32'h0000_0005, 1, 32'hffff_ffff, 1, 1);
        drain();
        // range edges, lowest threshold, most negative scale
        program_all(32'h8000_0000, 32'hffff_0000, 32'h0001_0000, 4'b0011, 32'h8000_0000);
        send_voxel(32'hffff_0000, 1, 32'h0, 0, 0);
        send_voxel(32'h0001_0000, 1, 32'h0, 0, 0);
        send_voxel(32'h0000_8000, 1, 32'h8000_0000, 0, 0);
        send_voxel(32'hffff_ffff, 1, 32'h8000_0001, 1, 1);
        send_voxel(32'h0000_0000, 1, 32'h0, 1, 1);
        drain();

        // random phases with fresh settings and idling patterns
        for (int ph = 0; ph < 8; ph++) begin
            program_all(pick32(), pick32(), pick32(), 4'($urandom_range(0, 15)),
                        ph == 2 ? 32'h0 : pick32());
            if (ph % 3 == 1) reg_write(RegRangeLow, 32'h8000_0000 + $urandom_range(0, 255));
            if (ph % 3 == 1) reg_write(RegRangeHigh, 32'h7fff_ffff - $urandom_range(0, 255));
            idle_mode = ph % 4;
            long_hold_req <= ph == 5;
            for (int n = 0; n < 92; n += len) begin
                len = $urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 14);
                for (int k = 0; k < len; k++)
                    send_voxel(pick32(), $urandom_range(0, 3) != 0, pick32(),
                               k == len - 1, $urandom_range(0, 3) != 0);
            end
            drain();
        end

        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
